/* rtl/uart_rx_line_assembler_top_assert.svh */
// Assertion macros shared by the line assembler checkers.
`ifndef UART_RX_LINE_ASSEMBLER_TOP_ASSERT_SVH
`define UART_RX_LINE_ASSEMBLER_TOP_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define URLA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("line assembler check failed");

// Check that a condition in one cycle brings a consequence in the next cycle.
`define URLA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("line assembler sequence check failed");

`endif

/* rtl/urla_pkg.sv */
// Shared types and constants for the UART receive line assembler.
`timescale 1ns / 1ps

package urla_pkg;

  // Default sizing
  localparam int unsigned LINE_CAPACITY_DFLT = 64;
  localparam int unsigned FIFO_LINES_DFLT    = 16;

  // Line terminators
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BYTE,
    ST_RD_SETUP,
    ST_RD_STREAM
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic latch;      // capture the incoming word
    logic do_byte;    // process the captured received byte
    logic rd_setup;   // look at the FIFO head, pop it, fetch first character
    logic rd_stream;  // emit one character, fetch the next one
  } dp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic fifo_empty;
    logic head_len_zero;
    logic stream_last;
  } dp_sts_t;

endpackage

/* rtl/uart_rx_line_assembler_top.sv */
// Top level of the UART receive line assembler with its line FIFO.
`timescale 1ns / 1ps

// A word is taken when start is high and busy is low. A received byte (mode 0)
// keeps busy high for one cycle after it is taken and gives no result. A read
// request (mode 1) first looks at the FIFO head; an empty FIFO or an empty line
// gives its single result while it does so, otherwise the line's characters
// follow, one per cycle, straight after it, since the line text sits in one
// memory with a single registered read port. Each result is shown for one
// cycle with result_valid_o high and cannot be held off; the last one carries
// last_of_line_o. No clearing pass runs after reset.
module uart_rx_line_assembler_top #(
  parameter int unsigned LINE_CAPACITY = urla_pkg::LINE_CAPACITY_DFLT,
  parameter int unsigned FIFO_LINES    = urla_pkg::FIFO_LINES_DFLT,
  localparam int unsigned LEN_W = $clog2(LINE_CAPACITY + 1),
  localparam int unsigned IDX_W = (LINE_CAPACITY > 1) ? $clog2(LINE_CAPACITY) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  logic             mode_i,
  input  logic [7:0]       rx_byte_i,
  input  logic             rx_fault_i,
  output logic             result_valid_o,
  output logic             read_status_o,
  output logic [LEN_W-1:0] line_length_o,
  output logic [IDX_W-1:0] char_index_o,
  output logic [7:0]       char_value_o,
  output logic             last_of_line_o,
  output logic [31:0]      error_count_o,
  output logic [31:0]      drop_count_o
);

  urla_pkg::dp_cmd_t cmd;
  urla_pkg::dp_sts_t sts;

  // Sequence the work
  urla_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .mode_i         (mode_i),
    .sts_i          (sts),
    .cmd_o          (cmd),
    .busy           (busy),
    .result_valid_o (result_valid_o)
  );

  // Assemble, store and read lines
  urla_dp #(
    .LINE_CAPACITY (LINE_CAPACITY),
    .FIFO_LINES    (FIFO_LINES)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .rx_byte_i      (rx_byte_i),
    .rx_fault_i     (rx_fault_i),
    .read_status_o  (read_status_o),
    .line_length_o  (line_length_o),
    .char_index_o   (char_index_o),
    .char_value_o   (char_value_o),
    .last_of_line_o (last_of_line_o),
    .error_count_o  (error_count_o),
    .drop_count_o   (drop_count_o)
  );

endmodule

/* rtl/urla_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module urla_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write one entry, register one read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/urla_ctrl.sv */
// Controller state machine: sequences byte handling and line reads.
`timescale 1ns / 1ps

module urla_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  logic              mode_i,
  input  urla_pkg::dp_sts_t sts_i,
  output urla_pkg::dp_cmd_t cmd_o,
  output logic              busy,
  output logic              result_valid_o
);

  urla_pkg::state_e state_q, state_d;

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= urla_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Advance state
  always_comb begin
    state_d = state_q;
    case (state_q)
      urla_pkg::ST_IDLE: begin
        if (start) begin
          state_d = mode_i ? urla_pkg::ST_RD_SETUP : urla_pkg::ST_BYTE;
        end
      end
      urla_pkg::ST_BYTE: begin
        state_d = urla_pkg::ST_IDLE;
      end
      urla_pkg::ST_RD_SETUP: begin
        if (sts_i.fifo_empty || sts_i.head_len_zero) begin
          state_d = urla_pkg::ST_IDLE;
        end else begin
          state_d = urla_pkg::ST_RD_STREAM;
        end
      end
      urla_pkg::ST_RD_STREAM: begin
        if (sts_i.stream_last) begin
          state_d = urla_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = urla_pkg::ST_IDLE;
      end
    endcase
  end

  // Drive commands and handshake outputs
  always_comb begin
    cmd_o          = '0;
    busy           = 1'b1;
    result_valid_o = 1'b0;
    case (state_q)
      urla_pkg::ST_IDLE: begin
        busy        = 1'b0;
        cmd_o.latch = start;
      end
      urla_pkg::ST_BYTE: begin
        cmd_o.do_byte = 1'b1;
      end
      urla_pkg::ST_RD_SETUP: begin
        cmd_o.rd_setup = 1'b1;
        result_valid_o = sts_i.fifo_empty || sts_i.head_len_zero;
      end
      urla_pkg::ST_RD_STREAM: begin
        cmd_o.rd_stream = 1'b1;
        result_valid_o  = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

/* rtl/urla_dp.sv */
// Datapath: partial line assembly, line FIFO storage, counters and read-out.
`timescale 1ns / 1ps

module urla_dp #(
  parameter int unsigned LINE_CAPACITY = urla_pkg::LINE_CAPACITY_DFLT,
  parameter int unsigned FIFO_LINES    = urla_pkg::FIFO_LINES_DFLT,
  localparam int unsigned LEN_W = $clog2(LINE_CAPACITY + 1),
  localparam int unsigned IDX_W = (LINE_CAPACITY > 1) ? $clog2(LINE_CAPACITY) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  urla_pkg::dp_cmd_t cmd_i,
  output urla_pkg::dp_sts_t sts_o,
  input  logic [7:0]        rx_byte_i,
  input  logic              rx_fault_i,
  output logic              read_status_o,
  output logic [LEN_W-1:0]  line_length_o,
  output logic [IDX_W-1:0]  char_index_o,
  output logic [7:0]        char_value_o,
  output logic              last_of_line_o,
  output logic [31:0]       error_count_o,
  output logic [31:0]       drop_count_o
);

  // One spare slot holds the line being assembled, so it never overlaps a stored line
  localparam int unsigned SLOTS  = FIFO_LINES + 1;
  localparam int unsigned SLOT_W = $clog2(SLOTS);
  localparam int unsigned CNT_W  = $clog2(FIFO_LINES + 1);
  localparam int unsigned DEPTH  = SLOTS * LINE_CAPACITY;
  localparam int unsigned ADDR_W = $clog2(DEPTH);

  // Captured word
  logic [7:0]        byte_q;
  logic              fault_q;

  // Line assembly and FIFO control
  logic [LEN_W-1:0]  plen_q, plen_d;
  logic              skip_q, skip_d;
  logic              disc_q, disc_d;
  logic [SLOT_W-1:0] head_q, head_d;
  logic [SLOT_W-1:0] tail_q, tail_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [31:0]       err_q, err_d;
  logic [31:0]       drop_q, drop_d;

  // Stored line lengths, one per slot
  logic [LEN_W-1:0]  len_mem_q [SLOTS];
  logic              len_we;

  // Read-out
  logic [SLOT_W-1:0] rd_slot_q;
  logic [LEN_W-1:0]  rd_len_q;
  logic [LEN_W-1:0]  rd_idx_q;

  // Text memory ports
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [ADDR_W-1:0] ram_raddr;
  logic [7:0]        ram_rdata;
  logic [SLOT_W-1:0] rd_base;
  logic [LEN_W-1:0]  rd_off;
  logic [LEN_W-1:0]  rd_idx_inc;
  logic              is_term;

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
    logic [SLOT_W-1:0] r;
    if (s == SLOT_W'(SLOTS - 1)) begin
      r = '0;
    end else begin
      r = SLOT_W'(s + 1'b1);
    end
    return r;
  endfunction

  // Capture the word
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      byte_q  <= rx_byte_i;
      fault_q <= rx_fault_i;
    end
  end

  assign is_term    = (byte_q == urla_pkg::CH_CR) || (byte_q == urla_pkg::CH_LF);
  assign rd_idx_inc = LEN_W'(rd_idx_q + 1'b1);

  // Process a received byte, pop the head on a read
  always_comb begin
    plen_d  = plen_q;
    skip_d  = skip_q;
    disc_d  = disc_q;
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    err_d   = err_q;
    drop_d  = drop_q;
    len_we  = 1'b0;
    ram_we  = 1'b0;
    if (cmd_i.do_byte) begin
      if (fault_q) begin
        err_d  = err_q + 32'd1;
        plen_d = '0;
        disc_d = 1'b1;
      end else if ((byte_q == urla_pkg::CH_LF) && skip_q) begin
        skip_d = 1'b0;
      end else begin
        skip_d = (byte_q == urla_pkg::CH_CR);
        if (is_term) begin
          if (!disc_q) begin
            if (count_q < CNT_W'(FIFO_LINES)) begin
              len_we  = 1'b1;
              tail_d  = next_slot(tail_q);
              count_d = CNT_W'(count_q + 1'b1);
            end else begin
              drop_d = drop_q + 32'd1;
            end
          end
          plen_d = '0;
          disc_d = 1'b0;
        end else if (!disc_q && (plen_q < LEN_W'(LINE_CAPACITY))) begin
          ram_we = 1'b1;
          plen_d = LEN_W'(plen_q + 1'b1);
        end
      end
    end
    if (cmd_i.rd_setup && (count_q != '0)) begin
      head_d  = next_slot(head_q);
      count_d = CNT_W'(count_q - 1'b1);
    end
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plen_q  <= '0;
      skip_q  <= 1'b0;
      disc_q  <= 1'b0;
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
      err_q   <= '0;
      drop_q  <= '0;
    end else begin
      plen_q  <= plen_d;
      skip_q  <= skip_d;
      disc_q  <= disc_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
      err_q   <= err_d;
      drop_q  <= drop_d;
    end
  end

  // Store the length of a committed line
  always_ff @(posedge clk_i) begin
    if (len_we) begin
      len_mem_q[tail_q] <= plen_q;
    end
  end

  // Load the read-out and advance through the line
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_setup) begin
      rd_slot_q <= head_q;
      rd_len_q  <= len_mem_q[head_q];
      rd_idx_q  <= '0;
    end else if (cmd_i.rd_stream) begin
      rd_idx_q  <= rd_idx_inc;
    end
  end

  // Address the text memory: partial line at the tail slot, reads from the head
  assign ram_waddr = ADDR_W'(ADDR_W'(tail_q) * ADDR_W'(LINE_CAPACITY))
                   + ADDR_W'(plen_q[IDX_W-1:0]);
  assign rd_base   = cmd_i.rd_setup ? head_q : rd_slot_q;
  assign rd_off    = cmd_i.rd_setup ? '0 : rd_idx_inc;
  assign ram_raddr = ADDR_W'(ADDR_W'(rd_base) * ADDR_W'(LINE_CAPACITY))
                   + ADDR_W'(rd_off);

  urla_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_text_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (byte_q),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Report status
  assign sts_o.fifo_empty    = (count_q == '0);
  assign sts_o.head_len_zero = (len_mem_q[head_q] == '0);
  assign sts_o.stream_last   = (rd_idx_inc == rd_len_q);

  // Build the result word
  assign read_status_o  = cmd_i.rd_setup && (count_q == '0);
  assign line_length_o  = cmd_i.rd_stream ? rd_len_q : '0;
  assign char_index_o   = cmd_i.rd_stream ? rd_idx_q[IDX_W-1:0] : '0;
  assign char_value_o   = cmd_i.rd_stream ? ram_rdata : 8'h00;
  assign last_of_line_o = cmd_i.rd_stream ? sts_o.stream_last : 1'b1;
  assign error_count_o  = err_q;
  assign drop_count_o   = drop_q;

endmodule

/* rtl/urla_checker.sv */
// Port-level checker for the line assembler, bound to the top level.
`timescale 1ns / 1ps
`include "uart_rx_line_assembler_top_assert.svh"

module urla_checker #(
  parameter int unsigned LINE_CAPACITY = urla_pkg::LINE_CAPACITY_DFLT,
  parameter int unsigned FIFO_LINES    = urla_pkg::FIFO_LINES_DFLT,
  localparam int unsigned LEN_W = $clog2(LINE_CAPACITY + 1),
  localparam int unsigned IDX_W = (LINE_CAPACITY > 1) ? $clog2(LINE_CAPACITY) : 1
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start,
  input logic             busy,
  input logic             mode_i,
  input logic             result_valid_o,
  input logic             read_status_o,
  input logic [LEN_W-1:0] line_length_o,
  input logic [IDX_W-1:0] char_index_o,
  input logic [7:0]       char_value_o,
  input logic             last_of_line_o
);

  logic             blank_ok;
  logic             next_in_order;
  logic [IDX_W-1:0] idx_next_q;

  // Shape of a blank single result
  assign blank_ok = last_of_line_o && (line_length_o == '0) && (char_value_o == 8'h00);

  // Remember the index that should follow the one shown
  always_ff @(posedge clk_i) begin
    idx_next_q <= IDX_W'(char_index_o + 1'b1);
  end

  assign next_in_order = result_valid_o && (char_index_o == idx_next_q);

  // Results only come while a read is in progress
  `URLA_ASSERT(a_result_while_busy, result_valid_o |-> busy)

  // An empty-FIFO answer is a single blank result
  `URLA_ASSERT(a_empty_blank, (result_valid_o && read_status_o) |-> blank_ok)

  // A received byte never produces a result
  `URLA_ASSERT_NEXT(a_byte_silent, start && !busy && !mode_i, busy && !result_valid_o)

  // Characters of a line come back to back in order
  `URLA_ASSERT_NEXT(a_stream_order, result_valid_o && !last_of_line_o, next_in_order)

  // The block goes idle after the last result
  `URLA_ASSERT_NEXT(a_idle_after_last, result_valid_o && last_of_line_o, !busy)

endmodule

bind uart_rx_line_assembler_top urla_checker #(
  .LINE_CAPACITY (LINE_CAPACITY),
  .FIFO_LINES    (FIFO_LINES)
) u_urla_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .mode_i         (mode_i),
  .result_valid_o (result_valid_o),
  .read_status_o  (read_status_o),
  .line_length_o  (line_length_o),
  .char_index_o   (char_index_o),
  .char_value_o   (char_value_o),
  .last_of_line_o (last_of_line_o)
);

/* tb/sv/tb_uart_rx_line_assembler_top.sv */
// Self-checking testbench for the UART receive line assembler: random and directed words.
`timescale 1ns / 1ps

module tb_uart_rx_line_assembler_top;

  localparam int unsigned LINE_CAP   = urla_pkg::LINE_CAPACITY_DFLT;
  localparam int unsigned FIFO_DEPTH = urla_pkg::FIFO_LINES_DFLT;
  localparam int unsigned LEN_W      = $clog2(LINE_CAP + 1);
  localparam int unsigned IDX_W      = (LINE_CAP > 1) ? $clog2(LINE_CAP) : 1;
  localparam int unsigned WORD_TOTAL = 300;
  localparam int unsigned DRAIN_CYC  = 2 * LINE_CAP + 16;

  localparam logic MODE_BYTE    = 1'b0;
  localparam logic MODE_READ    = 1'b1;
  localparam logic STATUS_DATA  = 1'b0;
  localparam logic STATUS_EMPTY = 1'b1;

  typedef enum int {TERM_CR, TERM_LF, TERM_CRLF} term_e;

  typedef struct packed {
    logic       mode;
    logic [7:0] data;
    logic       fault;
  } word_t;

  typedef struct packed {
    logic             status;
    logic [LEN_W-1:0] len;
    logic [IDX_W-1:0] idx;
    logic [7:0]       ch;
    logic             last;
    logic [31:0]      errs;
    logic [31:0]      drops;
  } line_char_t;

  logic             clk_i      = 1'b0;
  logic             rst_ni     = 1'b0;
  logic             start      = 1'b0;
  logic             mode_i     = MODE_BYTE;
  logic [7:0]       rx_byte_i  = 8'h00;
  logic             rx_fault_i = 1'b0;
  logic             busy;
  logic             result_valid_o;
  logic             read_status_o;
  logic [LEN_W-1:0] line_length_o;
  logic [IDX_W-1:0] char_index_o;
  logic [7:0]       char_value_o;
  logic             last_of_line_o;
  logic [31:0]      error_count_o;
  logic [31:0]      drop_count_o;

  uart_rx_line_assembler_top DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .mode_i         (mode_i),
    .rx_byte_i      (rx_byte_i),
    .rx_fault_i     (rx_fault_i),
    .result_valid_o (result_valid_o),
    .read_status_o  (read_status_o),
    .line_length_o  (line_length_o),
    .char_index_o   (char_index_o),
    .char_value_o   (char_value_o),
    .last_of_line_o (last_of_line_o),
    .error_count_o  (error_count_o),
    .drop_count_o   (drop_count_o)
  );

  always #5 clk_i = ~clk_i;

  // Words waiting to be sent and characters waiting to come out
  word_t      word_q[$];
  line_char_t char_q[$];
  word_t      cur_word;
  int unsigned words_taken = 0;
  int unsigned fails = 0;

  // Shadow copy of the line assembler
  logic [7:0]       part_text[LINE_CAP];
  int unsigned      part_len  = 0;
  bit               skip_lf   = 1'b0;
  bit               discard   = 1'b0;
  logic [7:0]       line_text[FIFO_DEPTH][LINE_CAP];
  int unsigned      line_len[FIFO_DEPTH];
  int unsigned      head      = 0;
  int unsigned      tail      = 0;
  int unsigned      fill_cnt  = 0;
  logic [31:0]      err_cnt   = '0;
  logic [31:0]      drop_cnt  = '0;

  task automatic push_char(input logic status, input int unsigned len, input int unsigned idx,
                           input logic [7:0] ch, input logic last);
    line_char_t r;
    r.status = status;
    r.len    = len[LEN_W-1:0];
    r.idx    = idx[IDX_W-1:0];
    r.ch     = ch;
    r.last   = last;
    r.errs   = err_cnt;
    r.drops  = drop_cnt;
    char_q.push_back(r);
  endtask

  // Advance the shadow state by one accepted word and queue the characters it emits
  task automatic assemble_word(input word_t w);
    int unsigned slot;
    int unsigned n;
    if (w.mode == MODE_READ) begin
      if (fill_cnt == 0) begin
        push_char(STATUS_EMPTY, 0, 0, 8'h00, 1'b1);
      end else begin
        slot = head;
        n = (line_len[slot] > LINE_CAP) ? LINE_CAP : line_len[slot];
        head = (head + 1) % FIFO_DEPTH;
        fill_cnt--;
        if (n == 0) begin
          push_char(STATUS_DATA, 0, 0, 8'h00, 1'b1);
        end else begin
          for (int unsigned i = 0; i < n; i++) begin
            push_char(STATUS_DATA, n, i, line_text[slot][i], i + 1 == n);
          end
        end
      end
    end else if (w.fault) begin
      err_cnt  = err_cnt + 1;
      part_len = 0;
      discard  = 1'b1;
    end else if (w.data == urla_pkg::CH_LF && skip_lf) begin
      skip_lf = 1'b0;
    end else begin
      skip_lf = (w.data == urla_pkg::CH_CR);
      if (w.data == urla_pkg::CH_CR || w.data == urla_pkg::CH_LF) begin
        if (!discard) begin
          if (fill_cnt < FIFO_DEPTH) begin
            for (int unsigned i = 0; i < part_len; i++) line_text[tail][i] = part_text[i];
            line_len[tail] = part_len;
            tail = (tail + 1) % FIFO_DEPTH;
            fill_cnt++;
          end else begin
            drop_cnt = drop_cnt + 1;
          end
        end
        part_len = 0;
        discard  = 1'b0;
      end else if (!discard && part_len < LINE_CAP) begin
        part_text[part_len] = w.data;
        part_len++;
      end
    end
  endtask

  // Sender idle rate per phase of the run
  function automatic int unsigned idle_pct();
    case (words_taken * 3 / WORD_TOTAL)
      0: begin
        return 25;
      end
      1: begin
        return 69;
      end
      default: begin
        return 0;
      end
    endcase
  endfunction

  // Drive words: hold while busy, otherwise present the next one or idle
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        assemble_word(cur_word);
        words_taken++;
      end
      if (start && busy) begin
        start <= 1'b1;
      end else if (word_q.size() != 0 && $urandom_range(0, 99) >= idle_pct()) begin
        cur_word   = word_q.pop_front();
        start      <= 1'b1;
        mode_i     <= cur_word.mode;
        rx_byte_i  <= cur_word.data;
        rx_fault_i <= cur_word.fault;
      end else begin
        start <= 1'b0;
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] exp, input logic [31:0] act);
    if (exp !== act) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp, act);
      fails++;
    end
  endtask

  // Compare each strobed character against the oldest expectation
  always @(posedge clk_i) begin
    line_char_t e;
    if (rst_ni && result_valid_o) begin
      if (char_q.size() == 0) begin
        $error("unexpected result: char_index %0d char_value %0d", char_index_o, char_value_o);
        fails++;
      end else begin
        e = char_q.pop_front();
        check_field("read_status", e.status, read_status_o);
        check_field("line_length", e.len, line_length_o);
        check_field("char_index", e.idx, char_index_o);
        check_field("char_value", e.ch, char_value_o);
        check_field("last_of_line", e.last, last_of_line_o);
        check_field("error_count", e.errs, error_count_o);
        check_field("drop_count", e.drops, drop_count_o);
      end
    end
  end

  task automatic push_word(input logic mode, input logic [7:0] data, input logic fault);
    word_t w;
    w.mode  = mode;
    w.data  = data;
    w.fault = fault;
    word_q.push_back(w);
  endtask

  task automatic push_read();
    push_word(MODE_READ, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  // Queue a line of random text with a random terminator, rarely hit by a fault
  task automatic push_line(input int unsigned len);
    logic [7:0] b;
    term_e      term;
    for (int unsigned i = 0; i < len; i++) begin
      b = 8'($urandom_range(0, 255));
      while ($urandom_range(0, 9) != 0 && (b == urla_pkg::CH_CR || b == urla_pkg::CH_LF)) begin
        b = 8'($urandom_range(0, 255));
      end
      push_word(MODE_BYTE, b, $urandom_range(0, 99) < 4);
    end
    term = term_e'($urandom_range(0, 2));
    case (term)
      TERM_CR: begin
        push_word(MODE_BYTE, urla_pkg::CH_CR, 1'b0);
      end
      TERM_LF: begin
        push_word(MODE_BYTE, urla_pkg::CH_LF, 1'b0);
      end
      default: begin
        push_word(MODE_BYTE, urla_pkg::CH_CR, 1'b0);
        push_word(MODE_BYTE, urla_pkg::CH_LF, 1'b0);
      end
    endcase
  endtask

  initial begin
    int unsigned pick;
    int unsigned len;

    // Directed: empty FIFO, empty line, CR LF pair, extreme bytes, discarded line
    push_read();
    push_word(MODE_BYTE, urla_pkg::CH_LF, 1'b0);
    push_read();
    push_word(MODE_BYTE, 8'h00, 1'b0);
    push_word(MODE_BYTE, 8'hFF, 1'b0);
    push_word(MODE_BYTE, urla_pkg::CH_CR, 1'b0);
    push_word(MODE_BYTE, urla_pkg::CH_LF, 1'b0);
    push_read();
    push_word(MODE_BYTE, 8'h78, 1'b0);
    push_word(MODE_BYTE, 8'hFF, 1'b1);
    push_word(MODE_BYTE, 8'h79, 1'b0);
    push_word(MODE_BYTE, urla_pkg::CH_CR, 1'b0);
    push_word(MODE_BYTE, urla_pkg::CH_LF, 1'b0);
    push_word(MODE_BYTE, urla_pkg::CH_LF, 1'b0);
    push_read();
    push_read();
    push_word(MODE_BYTE, urla_pkg::CH_CR, 1'b0);
    push_word(MODE_BYTE, urla_pkg::CH_CR, 1'b0);
    push_word(MODE_BYTE, urla_pkg::CH_LF, 1'b0);
    push_read();
    push_read();
    push_word(MODE_READ, 8'hFF, 1'b1);

    // Random: mostly well-formed lines and reads, some FIFO floods and noise
    while (word_q.size() < WORD_TOTAL) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        len = $urandom_range(0, 99);
        if (len < 85) len = $urandom_range(0, 6);
        else if (len < 95) len = $urandom_range(7, 20);
        else len = $urandom_range(LINE_CAP - 4, LINE_CAP + 6);
        push_line(len);
      end else if (pick < 85) begin
        push_read();
      end else if (pick < 90) begin
        for (int k = 0; k < FIFO_DEPTH + 2; k++) push_line($urandom_range(0, 2));
      end else if (pick < 95) begin
        push_word(MODE_BYTE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end else begin
        push_word(MODE_BYTE, urla_pkg::CH_LF, 1'b0);
      end
    end

    // Release reset, then drain everything
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (word_q.size() != 0 || start) @(posedge clk_i);
    while (char_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
    if (char_q.size() != 0) begin
      $error("%0d expected results never arrived", char_q.size());
      fails++;
    end
    if (fails == 0) begin
      $display("uart_rx_line_assembler_top verification clean");
    end else begin
      $display("uart_rx_line_assembler_top verification failed");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #5_000_000;
    $display("uart_rx_line_assembler_top verification failed");
    $finish;
  end

endmodule
